// ----- rtl/core/gfc_pkg.sv -----
`default_nettype none

package gfc_pkg;

    // Pulse counter width default and the width limits of the fixed fields.
    localparam int COUNT_WIDTH_DEF = 24;
    localparam int TICK_W          = 16;
    localparam int FREQ_W          = 20;
    localparam int SCAN_W          = 3;
    localparam int SCAN_POSITIONS  = 8;
    localparam int SEG_W           = 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TICKS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_GATE_TICKS   = CFG_INDEX_W'(1);
    localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = TICK_W'(100);
    localparam logic [TICK_W-1:0] GATE_TICKS_RST   = TICK_W'(1000);

    // Stream data widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Frequency range and digit conversion constants.
    localparam logic [FREQ_W-1:0] FREQ_MAX    = FREQ_W'(999999);
    localparam logic [FREQ_W-1:0] RECIP_TEN   = FREQ_W'(838861);
    localparam int                RECIP_SHIFT = 23;
    localparam logic [SCAN_W-1:0] FIRST_DIGIT_POS = SCAN_W'(1);
    localparam logic [SCAN_W-1:0] LAST_DIGIT_POS  = SCAN_W'(6);
    localparam logic [SCAN_W-1:0] POINT_POS       = SCAN_W'(4);
    localparam logic [SEG_W-1:0]  SEG_POINT       = 8'h80;

    // One transaction queued from the front part to the back part.
    typedef struct packed {
        logic              gate_open;
        logic              result_valid;
        logic [FREQ_W-1:0] frequency;
        logic [SCAN_W-1:0] scan_pos;
    } entry_t;

    // Fill state of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Seven-segment code of one decimal digit, segment a in bit 0.
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gfc_queue.sv -----
`default_nettype none

module gfc_queue
    import gfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire entry_t        push_entry,
    input  wire logic          pop,
    output entry_t             head_entry,
    output queue_status_t      status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry   = slot_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == CNT_W'(DEPTH));
    assign status.empty = (fill_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/core/gfc_front.sv -----
`default_nettype none

module gfc_front
    import gfc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]      cfg_data,
    input  wire logic                   in_valid,
    input  wire logic                   tick,
    input  wire logic                   pulse,
    input  wire queue_status_t          q_status,
    output logic                        in_ready,
    output logic                        push,
    output entry_t                      push_entry
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [TICK_W-1:0]      settle_reg;
    logic [TICK_W-1:0]      gate_len_reg;
    logic [TICK_W-1:0]      phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] pulse_reg, pulse_next;
    logic                   gate_reg, gate_next;
    logic [SCAN_W-1:0]      scan_reg, scan_next;
    logic [FREQ_W-1:0]      freq_reg, freq_next;

    logic [TICK_W-1:0]      phase_inc;
    logic [TICK_W:0]        close_at;
    logic                   open_hit;
    logic                   close_hit;
    logic [COUNT_WIDTH-1:0] count_base;
    logic [COUNT_WIDTH-1:0] corr_in;
    logic [3:0]             corr_sub;
    logic [COUNT_WIDTH-1:0] corr_diff;
    logic [FREQ_W-1:0]      corr_freq;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // Configuration writes; an index outside the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg   <= SETTLE_TICKS_RST;
            gate_len_reg <= GATE_TICKS_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_SETTLE_TICKS) begin
                settle_reg <= cfg_data;
            end else if (cfg_index == CFG_GATE_TICKS) begin
                gate_len_reg <= cfg_data;
            end
        end
    end

    // Phase compare against the open and close points.
    assign phase_inc = phase_reg + TICK_W'(1);
    assign close_at  = {1'b0, settle_reg} + {1'b0, gate_len_reg};
    assign open_hit  = tick && (phase_inc == settle_reg);
    assign close_hit = tick && ({1'b0, phase_inc} == close_at);

    // Piecewise correction of the closing count, then saturation.
    assign corr_in = open_hit ? '0 : pulse_reg;

    always_comb begin
        if (corr_in < COUNT_WIDTH'(100000)) begin
            corr_sub = 4'd0;
        end else if (corr_in < COUNT_WIDTH'(200000)) begin
            corr_sub = 4'd1;
        end else if (corr_in < COUNT_WIDTH'(300000)) begin
            corr_sub = 4'd3;
        end else if (corr_in < COUNT_WIDTH'(400000)) begin
            corr_sub = 4'd5;
        end else if (corr_in < COUNT_WIDTH'(500000)) begin
            corr_sub = 4'd7;
        end else if (corr_in < COUNT_WIDTH'(600000)) begin
            corr_sub = 4'd9;
        end else if (corr_in < COUNT_WIDTH'(700000)) begin
            corr_sub = 4'd10;
        end else begin
            corr_sub = 4'd11;
        end
        corr_diff = corr_in - COUNT_WIDTH'(corr_sub);
        if (corr_diff > COUNT_WIDTH'(FREQ_MAX)) begin
            corr_freq = FREQ_MAX;
        end else begin
            corr_freq = corr_diff[FREQ_W-1:0];
        end
    end

    // Next state of the gate sequencer for one transaction.
    always_comb begin
        phase_next = phase_reg;
        gate_next  = gate_reg;
        scan_next  = scan_reg;
        freq_next  = freq_reg;
        count_base = pulse_reg;
        if (tick) begin
            phase_next = phase_inc;
            scan_next  = scan_reg + SCAN_W'(1);
        end
        if (open_hit) begin
            gate_next  = 1'b1;
            count_base = '0;
        end
        if (close_hit) begin
            gate_next  = 1'b0;
            phase_next = '0;
            count_base = '0;
            freq_next  = corr_freq;
        end
        pulse_next = count_base;
        if (gate_next && pulse && (count_base != COUNT_MAX)) begin
            pulse_next = count_base + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            pulse_reg <= '0;
            gate_reg  <= 1'b0;
            scan_reg  <= '0;
            freq_reg  <= '0;
        end else if (push) begin
            phase_reg <= phase_next;
            pulse_reg <= pulse_next;
            gate_reg  <= gate_next;
            scan_reg  <= scan_next;
            freq_reg  <= freq_next;
        end
    end

    // The scan position is the one sampled at the start of the transaction.
    assign push_entry.gate_open    = gate_next;
    assign push_entry.result_valid = close_hit;
    assign push_entry.frequency    = freq_next;
    assign push_entry.scan_pos     = scan_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gfc_back.sv -----
`default_nettype none

module gfc_back
    import gfc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire entry_t               head_entry,
    input  wire queue_status_t        q_status,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [M_TDATA_W-1:0]      out_data
);

    localparam logic B_PASS = 1'b0;
    localparam logic B_CONV = 1'b1;
    localparam int   PROD_W = 2 * FREQ_W;

    logic                state_reg, state_next;
    logic [SCAN_W-1:0]   digit_pos_reg, digit_pos_next;
    logic [FREQ_W-1:0]   work_reg, work_next;
    logic [SEG_W-1:0]    disp_reg [SCAN_POSITIONS];
    logic                out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [PROD_W-1:0]   prod;
    logic [FREQ_W-1:0]   quot;
    logic [FREQ_W-1:0]   quot_x10;
    logic [3:0]          digit;
    logic [SEG_W-1:0]    digit_seg;
    logic [SEG_W-1:0]    shown_seg;
    logic [SEG_W-1:0]    scan_sel;

    // New transactions wait while the display digits are being rebuilt.
    assign pop = (state_reg == B_PASS) && !q_status.empty && (!out_valid_reg || out_ready);

    // One decimal digit per cycle through a reciprocal multiply by ten.
    assign prod      = work_reg * RECIP_TEN;
    assign quot      = FREQ_W'(prod[PROD_W-1:RECIP_SHIFT]);
    assign quot_x10  = (quot << 3) + (quot << 1);
    assign digit     = 4'(work_reg - quot_x10);
    assign digit_seg = seg_code(digit) | ((digit_pos_reg == POINT_POS) ? SEG_POINT : '0);

    // Conversion sequencer.
    always_comb begin
        state_next     = state_reg;
        digit_pos_next = digit_pos_reg;
        work_next      = work_reg;
        unique case (state_reg)
            B_PASS: begin
                if (pop && head_entry.result_valid) begin
                    state_next     = B_CONV;
                    digit_pos_next = FIRST_DIGIT_POS;
                    work_next      = head_entry.frequency;
                end
            end
            B_CONV: begin
                work_next      = quot;
                digit_pos_next = digit_pos_reg + SCAN_W'(1);
                if (digit_pos_reg == LAST_DIGIT_POS) begin
                    state_next = B_PASS;
                end
            end
            default: begin
                state_next = B_PASS;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_PASS;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        digit_pos_reg <= digit_pos_next;
        work_reg      <= work_next;
    end

    // Display store, blank after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SCAN_POSITIONS; i++) begin
                disp_reg[i] <= '0;
            end
        end else if (state_reg == B_CONV) begin
            disp_reg[digit_pos_reg] <= digit_seg;
        end
    end

    // Output register for the result transaction.
    assign shown_seg = ~disp_reg[head_entry.scan_pos];
    assign scan_sel  = ~(SEG_W'(1) << head_entry.scan_pos);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= {2'b00, shown_seg, scan_sel, head_entry.frequency,
                             head_entry.result_valid, head_entry.gate_open};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gated_frequency_counter_display.sv -----
`default_nettype none

// Gate-time frequency counter with an eight-position multiplexed display.
// Every input transaction carries a time base tick and a pulse flag and
// yields exactly one result transaction. The block takes one transaction per
// clock while the queue has room; each transaction that closes the gate
// starts a conversion in the back part, where the shown value is split into
// decimal digits one digit per cycle through a multiply by the reciprocal of
// ten. A four-entry queue between the sequencer and the display part absorbs
// up to four transactions of each pause when the input has gaps. Under
// continuous input the queue holds three or four entries after the first
// close, so every gate close then holds the input.
// Configuration (index 0 settle_ticks, index 1 gate_ticks) may be written
// only while no transaction is in flight.
module gated_frequency_counter_display
    import gfc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Configuration write channel.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]      cfg_data,
    // Input stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // tick[0], pulse[1], zero[7:2]
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // gate_open[0], result_valid[1], frequency[21:2], scan_select[29:22],
    // scan_segments[37:30], zero[39:38]
    output logic [M_TDATA_W-1:0]        m_tdata
);

    logic          push;
    logic          pop;
    entry_t        push_entry;
    entry_t        head_entry;
    queue_status_t q_status;

    assign cfg_ready = 1'b1;

    gfc_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .tick       (s_tdata[0]),
        .pulse      (s_tdata[1]),
        .q_status   (q_status),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    gfc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    gfc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule

`default_nettype wire

// ----- tb/freq_display_checker.sv -----
// Watches the configuration, input and result channels of the frequency
// counter. It predicts every result transaction and compares it field by field.
module freq_display_checker
    import gfc_pkg::*;
#(
    parameter int COUNT_W = COUNT_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]      cfg_data,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_TDATA_W-1:0]   m_tdata,
    output int                          mismatches,
    output int                          readings_pending,
    output int                          readings_checked,
    output int                          closes_seen
);

    // One result transaction, laid out as on m_tdata with gate_open in bit 0.
    typedef struct packed {
        logic [SEG_W-1:0]  scan_segments;
        logic [SEG_W-1:0]  scan_select;
        logic [FREQ_W-1:0] frequency;
        logic              result_valid;
        logic              gate_open;
    } freq_reading_t;

    // Segment codes of the digits 0 to 9, digit 0 in the lowest byte.
    localparam logic [10*SEG_W-1:0] DIGIT_SEGS = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    // Predicted state of the counter and its display.
    logic [TICK_W-1:0]  cfg_settle;
    logic [TICK_W-1:0]  cfg_gate;
    logic [TICK_W-1:0]  phase_ticks;
    logic [COUNT_W-1:0] pulse_tally;
    logic               gate_on;
    logic [SEG_W-1:0]   seg_store [SCAN_POSITIONS];
    logic [SCAN_W-1:0]  scan_at;
    logic [FREQ_W-1:0]  held_freq;

    freq_reading_t readings_due [$];

    int fail_tally  = 0;
    int check_tally = 0;
    int close_tally = 0;

    assign mismatches       = fail_tally;
    assign readings_checked = check_tally;
    assign closes_seen      = close_tally;

    initial readings_pending = 0;

    task automatic report_mismatch(input string what);
        if (fail_tally < 30) begin
            $display("checker: result %0d: %s", check_tally, what);
        end
        fail_tally++;
    endtask

    always @(posedge aclk) begin : watch
        freq_reading_t   want;
        freq_reading_t   got;
        logic [16:0]     close_at;
        longint unsigned n;
        longint unsigned f;
        int unsigned     v;
        int              pos;

        if (!aresetn) begin
            cfg_settle  = SETTLE_TICKS_RST;
            cfg_gate    = GATE_TICKS_RST;
            phase_ticks = '0;
            pulse_tally = '0;
            gate_on     = 1'b0;
            scan_at     = '0;
            held_freq   = '0;
            for (pos = 0; pos < SCAN_POSITIONS; pos++) begin
                seg_store[pos] = '0;
            end
            readings_due.delete();
        end else begin
            // Bench duty, unchecked: register writes only while nothing is in flight.
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SETTLE_TICKS) begin
                    cfg_settle = cfg_data;
                end else if (cfg_index == CFG_GATE_TICKS) begin
                    cfg_gate = cfg_data;
                end
            end

            // Every input transaction yields exactly one result.
            if (s_tvalid && s_tready) begin
                want.scan_select   = ~(SEG_W'(1) << scan_at);
                want.scan_segments = ~seg_store[scan_at];
                want.result_valid  = 1'b0;
                close_at = {1'b0, cfg_settle} + {1'b0, cfg_gate};
                if (s_tdata[0]) begin
                    scan_at     = scan_at + 1'b1;
                    phase_ticks = phase_ticks + 1'b1;
                    if (phase_ticks == cfg_settle) begin
                        pulse_tally = '0;
                        gate_on     = 1'b1;
                    end
                    if ({1'b0, phase_ticks} == close_at) begin
                        // Piecewise correction of the closing count, then saturation.
                        n = longint'(pulse_tally);
                        if (n < 100000) f = n;
                        else if (n < 200000) f = n - 1;
                        else if (n < 300000) f = n - 3;
                        else if (n < 400000) f = n - 5;
                        else if (n < 500000) f = n - 7;
                        else if (n < 600000) f = n - 9;
                        else if (n < 700000) f = n - 10;
                        else f = n - 11;
                        if (f > longint'(FREQ_MAX)) f = longint'(FREQ_MAX);
                        held_freq = FREQ_W'(f);
                        // Six decimal digits, units at the lowest position.
                        v = int'(held_freq);
                        for (pos = FIRST_DIGIT_POS; pos <= LAST_DIGIT_POS; pos++) begin
                            seg_store[pos] = DIGIT_SEGS[(v % 10) * SEG_W +: SEG_W];
                            v = v / 10;
                        end
                        seg_store[POINT_POS] = seg_store[POINT_POS] | SEG_POINT;
                        gate_on            = 1'b0;
                        pulse_tally        = '0;
                        phase_ticks        = '0;
                        want.result_valid  = 1'b1;
                    end
                end
                if (gate_on && s_tdata[1] && pulse_tally != '1) begin
                    pulse_tally = pulse_tally + 1'b1;
                end
                want.gate_open = gate_on;
                want.frequency = held_freq;
                readings_due.push_back(want);
            end

            // Compare each result transaction with the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = readings_due.pop_front();
                    got  = m_tdata[$bits(freq_reading_t)-1:0];
                    if (got.gate_open != want.gate_open) begin
                        report_mismatch($sformatf("gate_open got %0d, expected %0d",
                            got.gate_open, want.gate_open));
                    end
                    if (got.result_valid != want.result_valid) begin
                        report_mismatch($sformatf("result_valid got %0d, expected %0d",
                            got.result_valid, want.result_valid));
                    end
                    if (got.frequency != want.frequency) begin
                        report_mismatch($sformatf("frequency got %0d, expected %0d",
                            got.frequency, want.frequency));
                    end
                    if (got.scan_select != want.scan_select) begin
                        report_mismatch($sformatf("scan_select got 0x%02h, expected 0x%02h",
                            got.scan_select, want.scan_select));
                    end
                    if (got.scan_segments != want.scan_segments) begin
                        report_mismatch($sformatf("scan_segments got 0x%02h, expected 0x%02h",
                            got.scan_segments, want.scan_segments));
                    end
                    if (want.result_valid) begin
                        close_tally++;
                    end
                    check_tally++;
                end
            end
        end
        readings_pending <= readings_due.size();
    end

endmodule

// ----- tb/tb.sv -----
// Stimulus and verdict for the gated frequency counter. The checker beside
// the block predicts and compares every result transaction.
module tb;
    import gfc_pkg::*;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int DRAIN_CYCLES = 12;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SETTLE_TICKS;
    logic [TICK_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;    // tick[0], pulse[1], zero[7:2]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // gate_open[0], result_valid[1], frequency[21:2], scan_select[29:22],
    // scan_segments[37:30], zero[39:38]
    logic [M_TDATA_W-1:0]   m_tdata;

    int mismatches;
    int readings_pending;
    int readings_checked;
    int closes_seen;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    // Stimulus-side view of the tick phase, used only to start each
    // measurement and each new setting right after a gate close.
    logic [TICK_W-1:0] tick_phase  = '0;
    logic [16:0]       close_point = {1'b0, SETTLE_TICKS_RST} + {1'b0, GATE_TICKS_RST};

    gated_frequency_counter_display uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    freq_display_checker watch (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatches       (mismatches),
        .readings_pending (readings_pending),
        .readings_checked (readings_checked),
        .closes_seen      (closes_seen)
    );

    // Clock with a period of 10.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard limit on the run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Send one input transaction, with random idle cycles ahead of it.
    task automatic send_item(input logic tick, input logic pulse);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({pulse, tick});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (tick) begin
            tick_phase = tick_phase + 1'b1;
            if ({1'b0, tick_phase} == close_point) begin
                tick_phase = '0;
            end
        end
    endtask

    // Write both registers in two back-to-back transactions.
    task automatic write_config(input logic [TICK_W-1:0] settle,
                                input logic [TICK_W-1:0] gate_len);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SETTLE_TICKS;
        cfg_data  <= settle;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_GATE_TICKS;
        cfg_data  <= gate_len;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        close_point = {1'b0, settle} + {1'b0, gate_len};
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (readings_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Ticks with random pulses until the phase is back at its start.
    task automatic align_phase;
        while (tick_phase != '0) send_item(1'b1, 1'($urandom_range(1)));
    endtask

    // One measurement with the given tick count; pulse-only transactions are
    // mixed in between the ticks.
    task automatic measure_gate(input int ticks);
        repeat (ticks) begin
            if ($urandom_range(2) == 0) begin
                repeat ($urandom_range(1, 4)) send_item(1'b0, 1'($urandom_range(1)));
            end
            send_item(1'b1, 1'($urandom_range(1)));
        end
    endtask

    // Random phase: mostly whole measurements, some loose transactions.
    task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
        int stop_at;
        int settle;
        int gate_len;
        drain();
        settle   = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 6);
        gate_len = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 12);
        write_config(TICK_W'(settle), TICK_W'(gate_len));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(4) != 0) begin
                measure_gate(settle + gate_len);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
        end
        align_phase();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with a short gate: pulses while closed, on the
        // opening tick, between ticks and on the closing tick, then an empty
        // gate and a gate with a pulse on every tick.
        write_config(TICK_W'(2), TICK_W'(3));
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b1);
        repeat (5) send_item(1'b1, 1'b0);
        repeat (5) send_item(1'b1, 1'b1);
        drain();

        run_random_phase(0, 0, 125);
        run_random_phase(67, 0, 125);
        run_random_phase(0, 67, 125);
        run_random_phase(17, 17, 125);
        drain();

        $display("tb: %0d input transactions over a directed short gate",
                 items_sent);
        $display("tb: and four idle/stall phases; %0d results checked, %0d gate closes",
                 readings_checked, closes_seen);
        if (mismatches == 0 && readings_pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
